// ----- rtl/rpn_pkg.sv -----
// ----------------------------------------------------------------------------
// RPN calculator package
// Shared types, command codes and sizes for the RPN stack calculator.
// ----------------------------------------------------------------------------
package rpn_pkg;

	localparam int DEFAULT_STACK_DEPTH = 16;
	localparam int WORD_W = 32;

	typedef enum logic [3:0] {
		CMD_PUSH    = 4'd0,
		CMD_ADD     = 4'd1,
		CMD_SUB     = 4'd2,
		CMD_MUL     = 4'd3,
		CMD_DIV     = 4'd4,
		CMD_POW     = 4'd5,
		CMD_LOG     = 4'd6,
		CMD_SQRT    = 4'd7,
		CMD_SELECT  = 4'd8,
		CMD_INVALID = 4'd9,
		CMD_EOL     = 4'd10
	} cmd_t;

	typedef struct packed {
		logic [3:0]         command;
		logic signed [31:0] number;
	} rpn_in_t;

	typedef struct packed {
		logic signed [31:0] answer;
		logic               failed;
	} rpn_out_t;

	typedef enum logic [1:0] {
		OP_POW  = 2'd0,
		OP_DIV  = 2'd1,
		OP_LOG  = 2'd2,
		OP_SQRT = 2'd3
	} op_t;

	typedef struct packed {
		logic        start;
		op_t         op;
		logic [31:0] left;
		logic [31:0] right;
	} alu_req_t;

	typedef struct packed {
		logic        done;
		logic [31:0] result;
	} alu_rsp_t;

endpackage

// ----- rtl/rpn_stack_calculator_unit.sv -----
// ----------------------------------------------------------------------------
// RPN stack calculator unit
// Sequencer, operand stack and result register around the iterative unit.
// ----------------------------------------------------------------------------
// One request is taken at a time, and the input stalls while a request is in
// progress. The states that each request passes through after it is accepted:
// - None beyond idle: push, a request ignored after a fault, an invalid token,
//   and an underflow or overflow fault.
// - S_EOL: end of line.
// - S_RD1, S_RD2, S_EXEC: add and sub; S_MUL follows for mul.
// - S_RD1, S_RD2 (two reads), S_EXEC: select.
// - S_RD1, S_RD2, S_EXEC (S_RD1, S_EXEC for sqrt): an operator that faults on
//   its operand values.
// - S_RD1, S_EXEC, S_WAIT: sqrt; S_RD1, S_RD2, S_EXEC, S_WAIT: div.
// - The same as div for pow, with one squaring step per exponent bit.
// - The same as div for log, with one full division per quotient step, up to
//   30 steps for a base of 2.
// Stack reads are registered. The iterative unit works one bit per cycle. A
// finished answer waits in the result register, and only an end of line
// stalls behind it.
module rpn_stack_calculator_unit import rpn_pkg::*; #(
	parameter int STACK_DEPTH = DEFAULT_STACK_DEPTH
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	input  rpn_in_t  in_data,
	output logic     out_valid,
	input  logic     out_stall,
	output rpn_out_t out_data
);

	localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int CW = $clog2(STACK_DEPTH + 1);

	typedef enum logic [2:0] {
		S_IDLE, S_RD1, S_RD2, S_EXEC, S_MUL, S_WAIT, S_EOL
	} state_t;

	state_t         state_q;
	logic [3:0]     cmd_q;
	logic [CW-1:0]  count_q;
	logic           err_q;
	logic [31:0]    stack_mem [STACK_DEPTH];
	logic [31:0]    rd_q;
	logic [31:0]    r_q;
	logic [31:0]    l_q;
	logic [31:0]    c_q;
	logic [31:0]    prod_s1;
	logic [AW-1:0]  rd_addr;
	logic [AW-1:0]  wr_addr;
	logic [31:0]    wr_data;
	logic           wr_en;
	logic [1:0]     rd_step_q;
	alu_req_t       alu_req;
	alu_rsp_t       alu_rsp;

	rpn_iter_unit u_iter (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (alu_req),
		.rsp   (alu_rsp)
	);

	assign in_stall = (state_q != S_IDLE)
		|| (out_valid && out_stall && in_data.command == CMD_EOL);

	always_ff @(posedge clk) begin
		if (wr_en) stack_mem[wr_addr] <= wr_data;
		rd_q <= stack_mem[rd_addr];
	end

	always_comb begin
		rd_addr = AW'(count_q - CW'(1) - CW'(rd_step_q));
		if (state_q == S_IDLE) rd_addr = AW'(in_data.command == CMD_EOL ? CW'(0)
			: count_q - CW'(1));
	end

	logic [31:0] op_res;
	logic        op_fault;
	logic        use_alu;
	op_t         alu_op;
	always_comb begin
		op_res   = '0;
		op_fault = 1'b0;
		use_alu  = 1'b0;
		alu_op   = OP_POW;
		case (cmd_q)
			CMD_ADD: op_res = l_q + r_q;
			CMD_SUB: op_res = l_q - r_q;
			CMD_DIV: begin
				op_fault = (r_q == '0);
				use_alu  = 1'b1;
				alu_op   = OP_DIV;
			end
			CMD_POW: begin
				op_fault = r_q[31];
				use_alu  = 1'b1;
				alu_op   = OP_POW;
			end
			CMD_LOG: begin
				op_fault = ($signed(r_q) <= 32'sd1);
				use_alu  = 1'b1;
				alu_op   = OP_LOG;
			end
			CMD_SQRT: begin
				op_fault = r_q[31];
				use_alu  = 1'b1;
				alu_op   = OP_SQRT;
			end
			CMD_SELECT: op_res = (c_q != '0) ? l_q : r_q;
			default: op_res = '0;
		endcase
	end

	logic [CW-1:0] need;
	always_comb begin
		case (cmd_q)
			CMD_SQRT:   need = CW'(1);
			CMD_SELECT: need = CW'(3);
			default:    need = CW'(2);
		endcase
	end

	always_comb begin
		alu_req.start = (state_q == S_EXEC) && use_alu && !op_fault;
		alu_req.op    = alu_op;
		alu_req.left  = l_q;
		alu_req.right = r_q;
	end

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = AW'(count_q - CW'(1));
		wr_data = op_res;
		if (state_q == S_IDLE && in_valid && !in_stall && in_data.command == CMD_PUSH
			&& !err_q && count_q < CW'(STACK_DEPTH)) begin
			wr_en   = 1'b1;
			wr_addr = AW'(count_q);
			wr_data = in_data.number;
		end else if (state_q == S_EXEC && !use_alu) begin
			wr_en   = 1'b1;
			wr_addr = AW'(count_q - need);
		end else if (state_q == S_MUL) begin
			wr_en   = 1'b1;
			wr_addr = AW'(count_q - CW'(2));
			wr_data = prod_s1;
		end else if (state_q == S_WAIT && alu_rsp.done) begin
			wr_en   = 1'b1;
			wr_addr = AW'(count_q - need);
			wr_data = alu_rsp.result;
		end
	end

	always_ff @(posedge clk) prod_s1 <= l_q * r_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			count_q   <= '0;
			err_q     <= 1'b0;
			out_valid <= 1'b0;
			rd_step_q <= '0;
		end else begin
			if (out_valid && !out_stall) out_valid <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (in_valid && !in_stall) begin
						cmd_q     <= in_data.command;
						rd_step_q <= 2'd1;
						if (in_data.command == CMD_EOL) begin
							state_q <= S_EOL;
						end else if (err_q) begin
							state_q <= S_IDLE;
						end else if (in_data.command == CMD_PUSH) begin
							if (count_q < CW'(STACK_DEPTH)) count_q <= count_q + CW'(1);
							else err_q <= 1'b1;
						end else if ((in_data.command >= CMD_ADD &&
							in_data.command <= CMD_SELECT)) begin
							if (count_q < ((in_data.command == CMD_SQRT) ? CW'(1) :
								(in_data.command == CMD_SELECT) ? CW'(3) : CW'(2)))
								err_q <= 1'b1;
							else
								state_q <= S_RD1;
						end else begin
							err_q <= 1'b1;
						end
					end
				end
				S_RD1: begin
					r_q <= rd_q;
					rd_step_q <= 2'd2;
					if (cmd_q == CMD_SQRT) state_q <= S_EXEC;
					else state_q <= S_RD2;
				end
				S_RD2: begin
					if (rd_step_q == 2'd2) begin
						l_q <= rd_q;
						if (cmd_q == CMD_SELECT) rd_step_q <= 2'd3;
						else state_q <= S_EXEC;
					end else begin
						c_q     <= rd_q;
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (op_fault) begin
						err_q   <= 1'b1;
						state_q <= S_IDLE;
					end else if (cmd_q == CMD_MUL) begin
						state_q <= S_MUL;
					end else if (use_alu) begin
						state_q <= S_WAIT;
					end else begin
						count_q <= count_q - need + CW'(1);
						state_q <= S_IDLE;
					end
				end
				S_MUL: begin
					count_q <= count_q - CW'(1);
					state_q <= S_IDLE;
				end
				S_WAIT: begin
					if (alu_rsp.done) begin
						count_q <= count_q - need + CW'(1);
						state_q <= S_IDLE;
					end
				end
				S_EOL: begin
					if (!err_q && count_q == CW'(1)) begin
						out_data.answer <= rd_q;
						out_data.failed <= 1'b0;
					end else begin
						out_data.answer <= '0;
						out_data.failed <= 1'b1;
					end
					out_valid <= 1'b1;
					count_q   <= '0;
					err_q     <= 1'b0;
					state_q   <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ----- rtl/rpn_iter_unit.sv -----
// ----------------------------------------------------------------------------
// RPN iterative unit
// Multi-cycle unit for power, truncating divide, floor log and floor sqrt.
// One step per cycle, with a subtractor shared by divide and log and two 32x32 multipliers for power.
// ----------------------------------------------------------------------------
module rpn_iter_unit import rpn_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  alu_req_t req,
	output alu_rsp_t rsp
);

	typedef enum logic [2:0] {
		S_IDLE, S_POW, S_DIV, S_LOG_DIV, S_LOG_CHK, S_SQRT, S_DONE
	} state_t;

	state_t      state_q;
	op_t         op_q;
	logic [31:0] acc_q;
	logic [31:0] base_q;
	logic [31:0] exp_q;
	logic [31:0] quo_q;
	logic [32:0] rem_q;
	logic [31:0] dvd_q;
	logic [31:0] dvs_q;
	logic [5:0]  cnt_q;
	logic        neg_q;
	logic [31:0] res_q;
	logic [31:0] bit_q;

	logic [32:0] rem_sh;
	logic [32:0] rem_sub;
	logic [31:0] quo_nx;
	logic [32:0] rem_nx;
	logic [31:0] sq_try;
	logic [31:0] mul_a;
	logic [31:0] mul_b;

	always_comb begin
		rem_sh  = {rem_q[31:0], dvd_q[31]};
		rem_sub = rem_sh - {1'b0, dvs_q};
		if (!rem_sub[32]) begin
			rem_nx = rem_sub;
			quo_nx = {quo_q[30:0], 1'b1};
		end else begin
			rem_nx = rem_sh;
			quo_nx = {quo_q[30:0], 1'b0};
		end
		sq_try = res_q + bit_q;
		mul_a  = acc_q * base_q;
		mul_b  = base_q * base_q;
	end

	assign rsp.done   = (state_q == S_DONE);
	assign rsp.result = acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (req.start) begin
						op_q <= req.op;
						unique case (req.op)
							OP_POW: begin
								acc_q   <= 32'd1;
								base_q  <= req.left;
								exp_q   <= req.right;
								state_q <= S_POW;
							end
							OP_DIV: begin
								neg_q   <= req.left[31] ^ req.right[31];
								dvd_q   <= req.left[31] ? -req.left : req.left;
								dvs_q   <= req.right[31] ? -req.right : req.right;
								quo_q   <= '0;
								rem_q   <= '0;
								cnt_q   <= 6'd32;
								state_q <= S_DIV;
							end
							OP_LOG: begin
								acc_q   <= '0;
								exp_q   <= req.left;
								dvs_q   <= req.right;
								state_q <= S_LOG_CHK;
							end
							default: begin
								dvd_q   <= req.right;
								res_q   <= '0;
								bit_q   <= 32'h4000_0000;
								state_q <= S_SQRT;
							end
						endcase
					end
				end
				S_POW: begin
					if (exp_q == '0) begin
						state_q <= S_DONE;
					end else begin
						if (exp_q[0]) acc_q <= mul_a;
						base_q <= mul_b;
						exp_q  <= exp_q >> 1;
					end
				end
				S_DIV: begin
					quo_q <= quo_nx;
					rem_q <= rem_nx;
					dvd_q <= dvd_q << 1;
					cnt_q <= cnt_q - 6'd1;
					if (cnt_q == 6'd1) begin
						if (op_q == OP_DIV) begin
							acc_q   <= neg_q ? -quo_nx : quo_nx;
							state_q <= S_DONE;
						end else begin
							exp_q   <= quo_nx;
							acc_q   <= acc_q + 32'd1;
							state_q <= S_LOG_CHK;
						end
					end
				end
				S_LOG_CHK: begin
					if ($signed(exp_q) >= $signed(dvs_q)) begin
						dvd_q   <= exp_q;
						quo_q   <= '0;
						rem_q   <= '0;
						cnt_q   <= 6'd32;
						state_q <= S_DIV;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_SQRT: begin
					if (bit_q == '0) begin
						acc_q   <= res_q;
						state_q <= S_DONE;
					end else if (dvd_q >= sq_try) begin
						dvd_q <= dvd_q - sq_try;
						res_q <= (res_q >> 1) + bit_q;
						bit_q <= bit_q >> 2;
					end else begin
						res_q <= res_q >> 1;
						bit_q <= bit_q >> 2;
					end
				end
				S_DONE: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ----- dv/rpn_stack_calculator_unit_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RPN stack calculator unit test
// Feeds directed and random token lines through the valid/stall channels,
// predicts each end-of-line answer and checks it against the output channel.
// ----------------------------------------------------------------------------
module rpn_stack_calculator_unit_test;
	import rpn_pkg::*;

	localparam int DEPTH = DEFAULT_STACK_DEPTH;
	localparam int IDLE_LIMIT = 20000;
	localparam int SETTLE = 1500;

	logic     clk = 1'b0;
	logic     arst_n = 1'b0;
	logic     in_valid = 1'b0;
	logic     in_stall;
	rpn_in_t  in_data = '0;
	logic     out_valid;
	logic     out_stall = 1'b0;
	rpn_out_t out_data;

	rpn_stack_calculator_unit uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
	);

	always #4 clk = ~clk;

	rpn_in_t  token_q[$];
	bit       hold_q[$];
	rpn_out_t answer_q[$];
	int       fails = 0;
	int       answers_seen = 0;
	int       idle_cycles = 0;

	logic [31:0] stk[DEPTH];
	int          depth = 0;
	bit          err = 0;

	function automatic logic [31:0] isqrt(logic [31:0] v);
		logic [31:0] res, bit_pos;
		res = 0;
		bit_pos = 32'h4000_0000;
		while (bit_pos > v) bit_pos = bit_pos >> 2;
		while (bit_pos != 0) begin
			if (v >= res + bit_pos) begin
				v = v - (res + bit_pos);
				res = (res >> 1) + bit_pos;
			end else begin
				res = res >> 1;
			end
			bit_pos = bit_pos >> 2;
		end
		return res;
	endfunction

	task automatic calc_token(input rpn_in_t tok);
		logic [31:0] l, r, res, b, e;
		longint sl, sr, q;
		rpn_out_t ans;
		if (tok.command == CMD_EOL) begin
			ans.failed = err || depth != 1;
			ans.answer = ans.failed ? '0 : stk[0];
			answer_q.push_back(ans);
			depth = 0;
			err = 0;
			return;
		end
		if (err) return;
		case (tok.command)
			CMD_PUSH: begin
				if (depth >= DEPTH) err = 1;
				else begin
					stk[depth] = tok.number;
					depth++;
				end
			end
			CMD_SQRT: begin
				if (depth < 1 || stk[depth-1][31]) err = 1;
				else stk[depth-1] = isqrt(stk[depth-1]);
			end
			CMD_SELECT: begin
				if (depth < 3) err = 1;
				else begin
					res = (stk[depth-3] != 0) ? stk[depth-2] : stk[depth-1];
					depth -= 2;
					stk[depth-1] = res;
				end
			end
			CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV, CMD_POW, CMD_LOG: begin
				if (depth < 2) err = 1;
				else begin
					r = stk[depth-1];
					l = stk[depth-2];
					sl = $signed(l);
					sr = $signed(r);
					res = '0;
					case (tok.command)
						CMD_ADD: res = l + r;
						CMD_SUB: res = l - r;
						CMD_MUL: res = l * r;
						CMD_DIV: begin
							if (r == 0) err = 1;
							else begin
								q = sl / sr;
								res = q[31:0];
							end
						end
						CMD_POW: begin
							if (r[31]) err = 1;
							else begin
								res = 1;
								b = l;
								e = r;
								while (e != 0) begin
									if (e[0]) res = res * b;
									b = b * b;
									e = e >> 1;
								end
							end
						end
						default: begin
							if (sr <= 1) err = 1;
							else begin
								res = 0;
								while (sl >= sr) begin
									sl = sl / sr;
									res++;
								end
							end
						end
					endcase
					if (!err) begin
						depth--;
						stk[depth-1] = res;
					end
				end
			end
			default: err = 1;
		endcase
	endtask

	function automatic int draw_wait();
		return ($urandom_range(0, 2) == 0) ? $urandom_range(0, 12) : 0;
	endfunction

	// sender
	int gap = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			gap <= 0;
		end else begin
			if (in_valid && !in_stall) calc_token(in_data);
			if (in_valid && in_stall) begin
				// hold
			end else if (gap != 0) begin
				gap <= gap - 1;
				in_valid <= 1'b0;
			end else if (token_q.size() > 0 && !(hold_q[0] && answer_q.size() > 0)) begin
				in_data <= token_q.pop_front();
				void'(hold_q.pop_front());
				in_valid <= 1'b1;
				gap <= draw_wait();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver
	int wait_left = 0;
	always @(posedge clk or negedge arst_n) begin
		int n;
		rpn_out_t want;
		if (!arst_n) begin
			out_stall <= 1'b0;
			wait_left <= 0;
		end else begin
			n = wait_left;
			if (out_valid && !out_stall) begin
				answers_seen++;
				if (answer_q.size() == 0) begin
					$error("unexpected answer %0d failed %0b", out_data.answer, out_data.failed);
					fails++;
				end else begin
					want = answer_q.pop_front();
					if (out_data.answer !== want.answer) begin
						$error("answer: expected %0d, got %0d", want.answer, out_data.answer);
						fails++;
					end
					if (out_data.failed !== want.failed) begin
						$error("failed: expected %0b, got %0b", want.failed, out_data.failed);
						fails++;
					end
				end
				n = (answers_seen == 30) ? 400 : draw_wait();
			end else if (n > 0) begin
				n--;
			end
			wait_left <= n;
			out_stall <= (n != 0);
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	task automatic put(input cmd_t cmd, input logic [31:0] num, input bit hold = 0);
		rpn_in_t tok;
		tok.command = cmd;
		tok.number = num;
		token_q.push_back(tok);
		hold_q.push_back(hold);
	endtask

	function automatic logic [31:0] rand_num();
		case ($urandom_range(0, 5))
			0: return $urandom;
			1: return $urandom_range(0, 20);
			2: return -$urandom_range(0, 20);
			3: return ($urandom_range(0, 1) != 0) ? 32'h7fff_ffff : 32'h8000_0000;
			4: return $urandom_range(0, 1000);
			default: return $urandom & 32'h7fff_ffff;
		endcase
	endfunction

	task automatic random_line(input bit hold);
		rpn_in_t tok;
		int len, d, c;
		len = ($urandom_range(0, 15) == 0) ? $urandom_range(14, 19) : $urandom_range(1, 10);
		d = 0;
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(0, 19) == 0) begin
				tok.command = 4'($urandom_range(0, 15));
				tok.number = $urandom;
				if (tok.command == CMD_EOL) tok.command = CMD_INVALID;
				token_q.push_back(tok);
				hold_q.push_back(hold && i == 0);
				continue;
			end
			if (d < 2 || ($urandom_range(0, 2) == 0 && len > 12)) begin
				put(CMD_PUSH, rand_num(), hold && i == 0);
				d++;
			end else begin
				c = $urandom_range(1, 8);
				if (c == CMD_SELECT && d < 3) c = CMD_SUB;
				put(cmd_t'(c), $urandom, hold && i == 0);
				if (c == CMD_SELECT) d -= 2;
				else if (c != CMD_SQRT) d--;
			end
		end
		put(CMD_EOL, $urandom);
	endtask

	initial begin
		put(CMD_PUSH, 32'h7fff_ffff); put(CMD_PUSH, 1); put(CMD_ADD, 0); put(CMD_EOL, 0);
		put(CMD_PUSH, 32'h8000_0000); put(CMD_PUSH, -1); put(CMD_DIV, 0); put(CMD_EOL, 0);
		put(CMD_PUSH, 5); put(CMD_PUSH, 0); put(CMD_DIV, 0); put(CMD_PUSH, 1); put(CMD_EOL, 0);
		put(CMD_PUSH, 3); put(CMD_PUSH, 0); put(CMD_POW, 0); put(CMD_EOL, 0);
		put(CMD_PUSH, 2); put(CMD_PUSH, -1); put(CMD_POW, 0); put(CMD_EOL, 0);
		put(CMD_PUSH, 1000); put(CMD_PUSH, 10); put(CMD_LOG, 0); put(CMD_EOL, 0);
		put(CMD_PUSH, 3); put(CMD_PUSH, 10); put(CMD_LOG, 0); put(CMD_EOL, 0);
		put(CMD_PUSH, 5); put(CMD_PUSH, 1); put(CMD_LOG, 0); put(CMD_EOL, 0);
		put(CMD_PUSH, 32'h7fff_ffff); put(CMD_SQRT, 0); put(CMD_EOL, 0);
		put(CMD_PUSH, -4); put(CMD_SQRT, 0); put(CMD_EOL, 0);
		put(CMD_PUSH, 0); put(CMD_PUSH, 9); put(CMD_PUSH, 8); put(CMD_SELECT, 0); put(CMD_EOL, 0);
		put(CMD_PUSH, -3); put(CMD_PUSH, 9); put(CMD_PUSH, 8); put(CMD_SELECT, 0); put(CMD_EOL, 0);
		put(CMD_PUSH, -7); put(CMD_PUSH, 3); put(CMD_SUB, 0); put(CMD_PUSH, 3); put(CMD_MUL, 0);
		put(CMD_EOL, 0);
		put(CMD_PUSH, 1); put(CMD_ADD, 0); put(CMD_EOL, 0);
		put(CMD_INVALID, 0); put(CMD_EOL, 0);
		put(cmd_t'(4'd15), 32'hffff_ffff); put(CMD_EOL, 0);
		put(CMD_EOL, 0);
		for (int i = 0; i < DEPTH + 1; i++) put(CMD_PUSH, i);
		put(CMD_EOL, 0);
		for (int n = 0; token_q.size() < 1650; n++) random_line(n % 60 == 59);

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		do @(negedge clk);
		while (token_q.size() != 0 || in_valid || answer_q.size() != 0);
		repeat (SETTLE) @(posedge clk);
		if (fails == 0 && answer_q.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
